// ----- rtl/mpaf_pkg.sv -----
package mpaf_pkg;

	typedef enum logic [2:0] {
		FN_CONNECT    = 3'd0,
		FN_DISCONNECT = 3'd1,
		FN_SET        = 3'd2,
		FN_ADD        = 3'd3,
		FN_REMOVE     = 3'd4,
		FN_OWN_ADDR   = 3'd5,
		FN_NOTIFY     = 3'd6,
		FN_RELAY      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_RELAY  = 2'd3
	} scan_op_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_DECODE = 3'd1,
		ST_CLEAR  = 3'd2,
		ST_SCAN   = 3'd3,
		ST_WAIT   = 3'd4,
		ST_FINISH = 3'd5,
		ST_RESULT = 3'd6
	} seq_state_t;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_NOT_CONN = 3'd1;
	localparam logic [2:0] STS_NO_SLOT  = 3'd2;
	localparam logic [2:0] STS_BAD_TYPE = 3'd3;
	localparam logic [2:0] STS_BAD_CCC  = 3'd4;

	localparam logic [7:0]  LIST_CODE_ACCEPT = 8'h00;
	localparam logic [7:0]  LIST_CODE_REJECT = 8'h01;
	localparam logic [15:0] CCC_NOTIFY       = 16'h0001;
	localparam logic [15:0] ADDR_UNASSIGNED  = 16'h0000;
	localparam logic [15:0] ADDR_ALL_NODES   = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  func;
		logic [1:0]  client;
		logic [15:0] addr;
		logic [7:0]  list_code;
		logic [15:0] ccc_value;
	} req_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] slot;
		logic       send_status;
		logic       list_type;
		logic [4:0] entry_count;
		logic [3:0] relay_mask;
		logic       relayed;
		logic       start_beacons;
	} rsp_word_t;

	function automatic logic accepts(input kind_t kind, input logic hit,
		input logic [15:0] dst);
		logic ok;
		ok = 1'b0;
		if (kind == KIND_REJECT) begin
			ok = !hit;
		end else if (dst == ADDR_ALL_NODES) begin
			ok = 1'b1;
		end else if (kind == KIND_ACCEPT) begin
			ok = hit;
		end
		return ok;
	endfunction

endpackage

// ----- rtl/mpaf_ram.sv -----
module mpaf_ram import mpaf_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mpaf_seq.sv -----
module mpaf_seq import mpaf_pkg::*; #(
	parameter int CLIENTS = 4,
	parameter int FILTER_ENTRIES = 16,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_word_t     req,
	output logic          idle,
	output logic          mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [15:0]   mem_wdata,
	input  logic [15:0]   mem_rdata,
	output logic          res_valid,
	input  logic          res_take,
	output rsp_word_t     res
);

	localparam int EW  = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
	localparam int CNW = $clog2(FILTER_ENTRIES + 1);
	localparam int CLW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

	seq_state_t state_q, state_d;
	func_t      func_q;
	logic [1:0]  client_q;
	logic [15:0] dst_q;
	logic [7:0]  code_q;
	logic [15:0] ccc_q;
	scan_op_t    op_q;

	logic [CLIENTS-1:0] used_q;
	kind_t              kind_q [CLIENTS];

	logic [AW-1:0]  ptr_q, base_q;
	logic [EW-1:0]  ent_q;
	logic [CLW-1:0] rcl_q;

	logic           rd_vld_s1, rd_last_s1;
	logic [EW-1:0]  rd_ent_s1;
	logic [CLW-1:0] rd_cl_s1;

	logic               hit_q, emp_q;
	logic [EW-1:0]      hit_idx_q, emp_idx_q;
	logic [CNW-1:0]     cnt_q;
	logic [CLIENTS-1:0] mask_q;
	rsp_word_t          res_q;

	logic [CLW-1:0] cl, free_idx;
	logic           conn, free_any, set_ok, ent_last;
	logic [AW-1:0]  base, free_base;
	logic           d_nz, d_hit, wr_add, wr_rem;
	logic [CNW-1:0] cnt_fin;

	function automatic logic [4:0] sat_count(input logic [CNW-1:0] n);
		if (32'(n) > 31) begin
			return 5'd31;
		end
		return 5'(n);
	endfunction

	assign cl        = CLW'(client_q);
	assign conn      = (32'(client_q) < CLIENTS) && used_q[cl];
	assign base      = AW'(32'(cl) * FILTER_ENTRIES);
	assign free_base = AW'(32'(free_idx) * FILTER_ENTRIES);
	assign set_ok    = (code_q == LIST_CODE_ACCEPT) || (code_q == LIST_CODE_REJECT);
	assign ent_last  = ent_q == EW'(FILTER_ENTRIES - 1);
	assign d_nz      = mem_rdata != ADDR_UNASSIGNED;
	assign d_hit     = d_nz && (mem_rdata == dst_q);
	assign wr_add    = (op_q == OP_ADD) && (dst_q != ADDR_UNASSIGNED) && !hit_q && emp_q;
	assign wr_rem    = (op_q == OP_REMOVE) && hit_q;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = CLIENTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = CLW'(i);
			end
		end
	end

	always_comb begin
		priority if (wr_add) begin
			cnt_fin = CNW'(cnt_q + 1'b1);
		end else if (wr_rem) begin
			cnt_fin = CNW'(cnt_q - 1'b1);
		end else begin
			cnt_fin = cnt_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (func_q)
					FN_CONNECT: state_d = free_any ? ST_CLEAR : ST_RESULT;
					FN_SET: begin
						if (!conn) begin
							state_d = ST_RESULT;
						end else begin
							state_d = set_ok ? ST_CLEAR : ST_SCAN;
						end
					end
					FN_ADD, FN_REMOVE: state_d = conn ? ST_SCAN : ST_RESULT;
					FN_OWN_ADDR: begin
						if (conn && (kind_q[cl] == KIND_ACCEPT || kind_q[cl] == KIND_REJECT)) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_RESULT;
						end
					end
					FN_RELAY: state_d = ST_SCAN;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_CLEAR: begin
				if (ent_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (ent_last && (op_q != OP_RELAY || rcl_q == CLW'(CLIENTS - 1))) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT:   state_d = ST_FINISH;
			ST_FINISH: state_d = ST_RESULT;
			ST_RESULT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idle      = state_q == ST_IDLE;
		res_valid = state_q == ST_RESULT;
		mem_we    = 1'b0;
		mem_addr  = ptr_q;
		mem_wdata = ADDR_UNASSIGNED;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_FINISH: begin
				mem_we    = wr_add || wr_rem;
				mem_addr  = AW'(base_q + AW'(wr_add ? emp_idx_q : hit_idx_q));
				mem_wdata = wr_add ? dst_q : ADDR_UNASSIGNED;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			rd_vld_s1 <= 1'b0;
			for (int i = 0; i < CLIENTS; i++) begin
				kind_q[i] <= KIND_NONE;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= state_q == ST_SCAN;
			if (state_q == ST_DECODE) begin
				unique case (func_q)
					FN_CONNECT: begin
						if (free_any) begin
							used_q[free_idx] <= 1'b1;
							kind_q[free_idx] <= KIND_NONE;
						end
					end
					FN_DISCONNECT: begin
						if (conn) begin
							used_q[cl] <= 1'b0;
						end
					end
					FN_SET: begin
						if (conn && set_ok) begin
							kind_q[cl] <= (code_q == LIST_CODE_ACCEPT) ? KIND_ACCEPT : KIND_REJECT;
						end
					end
					FN_NOTIFY: begin
						if (ccc_q == CCC_NOTIFY && conn && kind_q[cl] == KIND_NONE) begin
							kind_q[cl] <= KIND_ACCEPT;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ent_s1  <= ent_q;
		rd_last_s1 <= ent_last;
		rd_cl_s1   <= rcl_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q   <= func_t'(req.func);
					client_q <= req.client;
					dst_q    <= req.addr;
					code_q   <= req.list_code;
					ccc_q    <= req.ccc_value;
				end
			end
			ST_DECODE: begin
				res_q  <= '0;
				hit_q  <= 1'b0;
				emp_q  <= 1'b0;
				cnt_q  <= '0;
				mask_q <= '0;
				ent_q  <= '0;
				rcl_q  <= '0;
				ptr_q  <= base;
				base_q <= base;
				op_q   <= OP_COUNT;
				unique case (func_q)
					FN_CONNECT: begin
						ptr_q <= free_base;
						if (free_any) begin
							res_q.slot <= 2'(free_idx);
						end else begin
							res_q.status <= STS_NO_SLOT;
						end
					end
					FN_SET, FN_ADD, FN_REMOVE: begin
						if (!conn) begin
							res_q.status <= STS_NOT_CONN;
						end else begin
							res_q.send_status <= 1'b1;
							res_q.list_type   <= kind_q[cl] != KIND_ACCEPT;
							if (func_q == FN_ADD) begin
								op_q <= OP_ADD;
							end else if (func_q == FN_REMOVE) begin
								op_q <= OP_REMOVE;
							end else if (set_ok) begin
								res_q.list_type <= code_q != LIST_CODE_ACCEPT;
							end else begin
								res_q.status <= STS_BAD_TYPE;
							end
						end
					end
					FN_OWN_ADDR: begin
						if (!conn) begin
							res_q.status <= STS_NOT_CONN;
						end else if (kind_q[cl] == KIND_ACCEPT) begin
							op_q <= OP_ADD;
						end else begin
							op_q <= OP_REMOVE;
						end
					end
					FN_NOTIFY: begin
						if (ccc_q != CCC_NOTIFY) begin
							res_q.status <= STS_BAD_CCC;
						end else if (!conn) begin
							res_q.status <= STS_NOT_CONN;
						end else if (kind_q[cl] == KIND_NONE) begin
							res_q.start_beacons <= 1'b1;
						end
					end
					FN_RELAY: begin
						ptr_q <= '0;
						op_q  <= OP_RELAY;
					end
					default: begin
						if (!conn) begin
							res_q.status <= STS_NOT_CONN;
						end
					end
				endcase
			end
			ST_CLEAR, ST_SCAN: begin
				ptr_q <= AW'(ptr_q + 1'b1);
				if (ent_last) begin
					ent_q <= '0;
					rcl_q <= CLW'(rcl_q + 1'b1);
				end else begin
					ent_q <= EW'(ent_q + 1'b1);
				end
			end
			ST_FINISH: begin
				if (res_q.send_status) begin
					res_q.entry_count <= sat_count(cnt_fin);
				end
				if (op_q == OP_RELAY) begin
					res_q.relay_mask <= 4'(mask_q);
					res_q.relayed    <= |mask_q;
				end
			end
			default: ;
		endcase

		// fold in the word read in the previous cycle
		if (rd_vld_s1) begin
			if (op_q == OP_RELAY) begin
				if (rd_last_s1) begin
					mask_q[rd_cl_s1] <= used_q[rd_cl_s1] &&
						accepts(kind_q[rd_cl_s1], hit_q || d_hit, dst_q);
					hit_q <= 1'b0;
				end else if (d_hit) begin
					hit_q <= 1'b1;
				end
			end else begin
				if (d_nz) begin
					cnt_q <= CNW'(cnt_q + 1'b1);
				end
				if (d_hit && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_ent_s1;
				end
				if (!d_nz && !emp_q) begin
					emp_q     <= 1'b1;
					emp_idx_q <= rd_ent_s1;
				end
			end
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == ST_SCAN)
		else $error("read data valid outside a scan");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> 32'(cnt_q) <= FILTER_ENTRIES)
		else $error("entry count beyond table size");

	a_result_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && res_take) |=> state_q == ST_IDLE)
		else $error("result taken but sequencer not idle");

	a_mask_connected: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && op_q == OP_RELAY) |-> (mask_q & ~used_q) == '0)
		else $error("relay mask names a free slot");
`endif

endmodule

// ----- rtl/mesh_proxy_address_filter_top.sv -----
// Connect to a free slot and a valid set zero the client's table of FILTER_ENTRIES entries;
// add, remove, a bad set or own address on a list, each on a connected client, scan that
// table, and relay match scans all CLIENTS*FILTER_ENTRIES entries.
// Throughput: one word at a time; the table is walked one entry per cycle
// through the single port of the entry memory; the next word is taken once the result is held.
// Reset clears the connected flags and filter kinds; a table is zeroed by connect before use.
module mesh_proxy_address_filter_top import mpaf_pkg::*; #(
	parameter int CLIENTS = 4,
	parameter int FILTER_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int DEPTH = CLIENTS * FILTER_ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          idle, accept;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic          res_valid, res_take;
	rsp_word_t     res;
	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	assign req_stall = !idle;
	assign accept    = req_valid && idle;
	assign res_take  = !rsp_valid_q || !rsp_stall;

	mpaf_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	mpaf_seq #(
		.CLIENTS(CLIENTS),
		.FILTER_ENTRIES(FILTER_ENTRIES),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req(req),
		.idle(idle),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
